### rtl/biased_dfs_maze_carver_core_macros.svh
// Assertion macros for the maze carver core.
// Expects clk and rst_n in the scope of use.
`ifndef BIASED_DFS_MAZE_CARVER_CORE_MACROS_SVH
`define BIASED_DFS_MAZE_CARVER_CORE_MACROS_SVH

// same-cycle implication
`define BDMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bdmc_pkg.sv
// Shared types and constants for the maze carver core.
// No dependencies.
package bdmc_pkg;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int COORD_W    = 8;

    localparam logic [1:0] CFG_GRID_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_BIAS_LEVEL    = 2'd2;
    localparam logic [1:0] CFG_INVERT_CHANCE = 2'd3;

    typedef enum logic [1:0] {
        EV_STARTED   = 2'd0,
        EV_CARVED    = 2'd1,
        EV_BACKTRACK = 2'd2,
        EV_FINISHED  = 2'd3
    } ev_t;

    typedef enum logic [1:0] {
        DIR_N,
        DIR_S,
        DIR_E,
        DIR_W
    } dir_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CLEAR,
        OP_START,
        OP_RD_N,
        OP_RD_S,
        OP_RD_C,
        OP_EVAL,
        OP_WR_WALL,
        OP_PUSH,
        OP_POP_RD,
        OP_POP,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic action;
        logic empty;
        logic clr_last;
        logic push;
        logic more;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/bdmc_ctrl.sv
// Sequencer for the maze carver: start sweep, neighbor reads, carve or pop.
// Depends on bdmc_pkg.
module bdmc_ctrl
    import bdmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_op_t     op
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_START,
        ST_RD_N,
        ST_RD_S,
        ST_RD_C,
        ST_EVAL,
        ST_WR_WALL,
        ST_PUSH,
        ST_POP_RD,
        ST_POP,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = OP_IDLE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op = OP_LOAD;
                    if (!status.action)
                        state_next = ST_CLEAR;
                    else if (status.empty)
                        state_next = ST_DONE;
                    else
                        state_next = ST_RD_N;
                end
            end
            ST_CLEAR:
            begin
                op = OP_CLEAR;
                if (status.clr_last)
                    state_next = ST_START;
            end
            ST_START:
            begin
                op         = OP_START;
                state_next = ST_DONE;
            end
            ST_RD_N:
            begin
                op         = OP_RD_N;
                state_next = ST_RD_S;
            end
            ST_RD_S:
            begin
                op         = OP_RD_S;
                state_next = ST_RD_C;
            end
            ST_RD_C:
            begin
                op         = OP_RD_C;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                op = OP_EVAL;
                if (status.push)
                    state_next = ST_WR_WALL;
                else if (status.more)
                    state_next = ST_POP_RD;
                else
                    state_next = ST_DONE;
            end
            ST_WR_WALL:
            begin
                op         = OP_WR_WALL;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                op         = OP_PUSH;
                state_next = ST_DONE;
            end
            ST_POP_RD:
            begin
                op         = OP_POP_RD;
                state_next = ST_POP;
            end
            ST_POP:
            begin
                op         = OP_POP;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    op         = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/bdmc_datapath.sv
// Datapath of the maze carver: config registers, carve map, path stack,
// neighbor evaluation and the output register. Depends on bdmc_pkg.
module bdmc_datapath
    import bdmc_pkg::*;
#(
    parameter int MAX_DIM     = 64,
    parameter int STACK_DEPTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_op_t                op,
    output dp_status_t            status,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser
);

    localparam int LOG  = $clog2(MAX_DIM);
    localparam int SW   = (LOG >= 6) ? LOG + 6 : LOG + 7;
    localparam int CNTW = $clog2(STACK_DEPTH + 1);
    localparam int SI   = $clog2(STACK_DEPTH);

    // configuration
    logic [5:0] grid_w_reg;
    logic [5:0] grid_h_reg;
    logic [7:0] bias_level_reg;
    logic [7:0] invert_chance_reg;

    // latched request
    logic [5:0] start_x_reg;
    logic [5:0] start_y_reg;
    logic [7:0] rand_axis_reg;
    logic       rand_pick_reg;
    logic [7:0] rand_invert_reg;

    // walk state
    logic [CNTW-1:0] count_reg;
    logic            flipped_reg;
    logic [SW-1:0]   top_reg;
    logic [LOG-1:0]  clr_row_reg;

    logic [MAX_DIM-1:0] map_mem [MAX_DIM];
    logic [MAX_DIM-1:0] map_rd_reg;
    logic [LOG-1:0]     rd_row;
    logic               n_bit_reg;
    logic               s_bit_reg;

    logic [SW-1:0] stack_mem [STACK_DEPTH];
    logic [SW-1:0] stk_rd_reg;

    ev_t                event_reg;
    logic [COORD_W-1:0] wall_x_reg;
    logic [COORD_W-1:0] wall_y_reg;
    logic [COORD_W-1:0] room_x_reg;
    logic [COORD_W-1:0] room_y_reg;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [1:0]            m_user_reg;

    // decoded coordinates
    logic [LOG-1:0]      cx_l;
    logic [COORD_W-1:0]  cxw;
    logic [COORD_W-1:0]  cyw;
    logic [LOG-1:0]      cy_l;
    logic [LOG-1:0]      col_e;
    logic [LOG-1:0]      col_w;
    logic [COORD_W-1:0]  w_ext;
    logic [COORD_W-1:0]  h_ext;
    logic                col_ok;
    logic                row_ok;
    logic                open_n;
    logic                open_s;
    logic                open_e;
    logic                open_w;
    logic                vopen;
    logic                hopen;
    logic                can_push;
    logic [8:0]          bias;
    logic                vertical;
    dir_t                dir;
    logic [COORD_W-1:0]  nwall_x;
    logic [COORD_W-1:0]  nwall_y;
    logic [COORD_W-1:0]  nroom_x;
    logic [COORD_W-1:0]  nroom_y;
    logic [5:0]          sx_even;
    logic [5:0]          sy_even;
    logic [SW-1:0]       start_v;
    logic [SW-1:0]       room_v;
    logic [5:0]          out_cx;
    logic [5:0]          out_cy;
    logic [5:0]          out_wx;
    logic [5:0]          out_wy;

    assign cx_l    = top_reg[LOG-1:0];
    assign cxw     = COORD_W'(top_reg[LOG-1:0]);
    assign cyw     = COORD_W'(top_reg[SW-1:LOG]);
    assign cy_l    = LOG'(cyw);
    assign col_e   = cx_l + LOG'(2);
    assign col_w   = cx_l - LOG'(2);
    assign w_ext   = COORD_W'({grid_w_reg[5:1], 1'b1});
    assign h_ext   = COORD_W'({grid_h_reg[5:1], 1'b1});
    assign sx_even = {start_x_reg[5:1], 1'b0};
    assign sy_even = {start_y_reg[5:1], 1'b0};
    assign start_v = (SW'(sy_even) << LOG) + SW'(sx_even);
    assign room_v  = (SW'(room_y_reg) << LOG) + SW'(room_x_reg);

    // neighbor evaluation
    always_comb
    begin
        col_ok = (cxw >= COORD_W'(2)) && (cxw + COORD_W'(1) <= w_ext);
        row_ok = (cyw >= COORD_W'(2)) && (cyw + COORD_W'(1) <= h_ext);
        open_n = col_ok && (cyw >= COORD_W'(3)) && (cyw <= h_ext) && !n_bit_reg;
        open_s = col_ok && (cyw >= COORD_W'(1)) && (cyw + COORD_W'(2) <= h_ext)
                 && !s_bit_reg;
        open_e = row_ok && (cxw >= COORD_W'(1)) && (cxw + COORD_W'(2) <= w_ext)
                 && !map_rd_reg[col_e];
        open_w = row_ok && (cxw >= COORD_W'(3)) && (cxw <= w_ext) && !map_rd_reg[col_w];
        vopen    = open_n || open_s;
        hopen    = open_e || open_w;
        can_push = (vopen || hopen) && (count_reg < CNTW'(STACK_DEPTH));
        bias     = flipped_reg ? (9'd256 - {1'b0, bias_level_reg}) : {1'b0, bias_level_reg};
        if (vopen && hopen)
            vertical = ({1'b0, rand_axis_reg} > bias);
        else
            vertical = vopen;
        if (vertical)
        begin
            if (open_n && open_s)
                dir = rand_pick_reg ? DIR_N : DIR_S;
            else
                dir = open_n ? DIR_N : DIR_S;
        end
        else
        begin
            if (open_e && open_w)
                dir = rand_pick_reg ? DIR_E : DIR_W;
            else
                dir = open_e ? DIR_E : DIR_W;
        end
        nwall_x = cxw;
        nwall_y = cyw;
        nroom_x = cxw;
        nroom_y = cyw;
        case (dir)
            DIR_N:
            begin
                nwall_y = cyw - COORD_W'(1);
                nroom_y = cyw - COORD_W'(2);
            end
            DIR_S:
            begin
                nwall_y = cyw + COORD_W'(1);
                nroom_y = cyw + COORD_W'(2);
            end
            DIR_E:
            begin
                nwall_x = cxw + COORD_W'(1);
                nroom_x = cxw + COORD_W'(2);
            end
            DIR_W:
            begin
                nwall_x = cxw - COORD_W'(1);
                nroom_x = cxw - COORD_W'(2);
            end
            default:
            begin
                nwall_x = cxw;
            end
        endcase
    end

    always_comb
    begin
        case (op)
            OP_RD_N: rd_row = cy_l - LOG'(2);
            OP_RD_S: rd_row = cy_l + LOG'(2);
            default: rd_row = cy_l;
        endcase
    end

    assign status.action   = s_axis_tuser[0];
    assign status.empty    = (count_reg == '0);
    assign status.clr_last = (clr_row_reg == LOG'(MAX_DIM - 1));
    assign status.push     = can_push;
    assign status.more     = (count_reg > CNTW'(1));
    assign status.out_free = !m_valid_reg || m_axis_tready;

    // carve map
    always_ff @(posedge clk)
    begin
        case (op)
            OP_CLEAR:   map_mem[clr_row_reg] <= '0;
            OP_START:   map_mem[LOG'(sy_even)][LOG'(sx_even)] <= 1'b1;
            OP_WR_WALL: map_mem[LOG'(wall_y_reg)][LOG'(wall_x_reg)] <= 1'b1;
            OP_PUSH:    map_mem[LOG'(room_y_reg)][LOG'(room_x_reg)] <= 1'b1;
            default:    ;
        endcase
        map_rd_reg <= map_mem[rd_row];
    end

    // path stack
    always_ff @(posedge clk)
    begin
        if (op == OP_START)
            stack_mem[SI'(0)] <= start_v;
        else if (op == OP_PUSH)
            stack_mem[SI'(count_reg)] <= room_v;
        stk_rd_reg <= stack_mem[SI'(count_reg - CNTW'(1))];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg        <= 6'd63;
            grid_h_reg        <= 6'd63;
            bias_level_reg    <= 8'd128;
            invert_chance_reg <= 8'd5;
            count_reg         <= '0;
            flipped_reg       <= 1'b0;
            clr_row_reg       <= '0;
            m_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:    grid_w_reg        <= cfg_data[5:0];
                    CFG_GRID_HEIGHT:   grid_h_reg        <= cfg_data[5:0];
                    CFG_BIAS_LEVEL:    bias_level_reg    <= cfg_data;
                    CFG_INVERT_CHANCE: invert_chance_reg <= cfg_data;
                    default:           ;
                endcase
            end
            case (op)
                OP_CLEAR:
                begin
                    clr_row_reg <= clr_row_reg + LOG'(1);
                end
                OP_START:
                begin
                    count_reg   <= CNTW'(1);
                    flipped_reg <= 1'b0;
                end
                OP_EVAL:
                begin
                    if (!can_push)
                        count_reg <= count_reg - CNTW'(1);
                    if (rand_invert_reg < invert_chance_reg)
                        flipped_reg <= !flipped_reg;
                end
                OP_PUSH:
                begin
                    count_reg <= count_reg + CNTW'(1);
                end
                default:
                begin
                end
            endcase
            if (op == OP_OUT)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    assign out_cx = (count_reg == '0) ? 6'd0 : 6'(cxw);
    assign out_cy = (count_reg == '0) ? 6'd0 : 6'(cyw);
    assign out_wx = (event_reg == EV_CARVED) ? 6'(wall_x_reg) : 6'd0;
    assign out_wy = (event_reg == EV_CARVED) ? 6'(wall_y_reg) : 6'd0;

    // payload
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                start_x_reg     <= s_axis_tdata[5:0];
                start_y_reg     <= s_axis_tdata[11:6];
                rand_axis_reg   <= s_axis_tdata[19:12];
                rand_pick_reg   <= s_axis_tdata[20];
                rand_invert_reg <= s_axis_tdata[28:21];
                event_reg       <= EV_FINISHED;
            end
            OP_START:
            begin
                top_reg   <= start_v;
                event_reg <= EV_STARTED;
            end
            OP_RD_S:
            begin
                n_bit_reg <= map_rd_reg[cx_l];
            end
            OP_RD_C:
            begin
                s_bit_reg <= map_rd_reg[cx_l];
            end
            OP_EVAL:
            begin
                wall_x_reg <= nwall_x;
                wall_y_reg <= nwall_y;
                room_x_reg <= nroom_x;
                room_y_reg <= nroom_y;
                if (can_push)
                    event_reg <= EV_CARVED;
                else if (count_reg == CNTW'(1))
                    event_reg <= EV_FINISHED;
                else
                    event_reg <= EV_BACKTRACK;
            end
            OP_PUSH:
            begin
                top_reg <= room_v;
            end
            OP_POP:
            begin
                top_reg <= stk_rd_reg;
            end
            OP_OUT:
            begin
                m_data_reg <= {5'd0, 11'(count_reg), out_wy, out_wx, out_cy, out_cx};
                m_user_reg <= event_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

### rtl/biased_dfs_maze_carver_core.sv
// Top level of the biased depth-first maze carver.
// Depends on bdmc_pkg, bdmc_ctrl, bdmc_datapath and the assertion macro header.
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tuser: action; tdata: request fields
// m_axis    out  m_axis_tvalid/tready       tuser: event_res; tdata: result fields
// cfg       in   cfg_we                     cfg_index, cfg_data
//
// Start request: one carve-map row cleared per cycle, then the start cell is set.
// Walk step: three row reads of the single-port carve map, then
// two bit writes (carve) or a stack read (backtrack); no stack read when the pop
// empties the stack. A step on an empty stack goes straight to the output.
// One request in flight; a finished result waits in the output register
// while the next request is accepted. Reset clears control state only.
`include "biased_dfs_maze_carver_core_macros.svh"

module biased_dfs_maze_carver_core
    import bdmc_pkg::*;
#(
    parameter int MAX_DIM     = 64,
    parameter int STACK_DEPTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_x[5:0], start_y[11:6], rand_axis[19:12], rand_pick[20],
    // rand_invert[28:21], zero[31:29]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[0]
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cell_x[5:0], cell_y[11:6], wall_x[17:12], wall_y[23:18],
    // stack_depth[34:24], zero[39:35]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // event_res[1:0]
    output logic [1:0]            m_axis_tuser,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);

    dp_op_t     op;
    dp_status_t status;

    bdmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .op       (op)
    );

    bdmc_datapath #(
        .MAX_DIM     (MAX_DIM),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `BDMC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "ready held after accept")
    `BDMC_ASSERT_NOW(a_start_depth, m_axis_tvalid && (m_axis_tuser == EV_STARTED),
        (m_axis_tdata[34:24] == 11'd1) && !m_axis_tdata[0], "start result malformed")
    `BDMC_ASSERT_NOW(a_finish_empty, m_axis_tvalid && (m_axis_tuser == EV_FINISHED),
        m_axis_tdata[11:0] == 12'd0, "finished with nonzero top")
    `BDMC_ASSERT_NOW(a_carve_wall, m_axis_tvalid && (m_axis_tuser == EV_CARVED),
        (m_axis_tdata[17:12] != 6'd0) && (m_axis_tdata[23:18] != 6'd0),
        "carve without wall")

endmodule

### tb/sv/biased_dfs_maze_carver_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for biased_dfs_maze_carver_core: a directed table, then random
// start/step walks over several register settings, checked against a behavioral predictor.
// Depends on bdmc_pkg and the core RTL; reads no files.
module biased_dfs_maze_carver_core_tb
    import bdmc_pkg::*;
();

    localparam int GRID_DIM   = 64;
    localparam int STACK_CAP  = 1024;
    localparam int SETTLE_CYC = 80;
    localparam int LIMIT_CYC  = 400000;
    localparam int LONG_HOLD  = 400;
    localparam int NUM_PHASES = 10;
    localparam int MAX_REPORT = 100;

    typedef struct packed {
        logic       action;
        logic [5:0] start_x;
        logic [5:0] start_y;
        logic [7:0] rand_axis;
        logic       rand_pick;
        logic [7:0] rand_invert;
    } carve_req_t;

    typedef struct packed {
        ev_t         ev;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [5:0]  wall_x;
        logic [5:0]  wall_y;
        logic [10:0] depth;
    } carve_res_t;

    typedef struct packed {
        carve_req_t req;
        logic       typed;
        carve_res_t res;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [7:0]            cfg_data;

    // predictor state and register copies
    logic       carved_bits [0:GRID_DIM*GRID_DIM-1];
    logic [11:0] path_cells [0:STACK_CAP-1];
    int         path_len;
    logic       bias_inv;
    logic [5:0] cfg_w;
    logic [5:0] cfg_h;
    logic [7:0] cfg_bias;
    logic [7:0] cfg_flip;

    carve_res_t expected_results [$];
    plan_row_t  plan [$];
    carve_res_t got;
    carve_res_t want;

    bit tx_idle_on;
    bit rx_idle_on;
    int hold_req;
    int hold_seen;
    int hold_left;
    int cycle_count;
    int n_errors;
    int n_sent;
    int n_results;
    int n_settings;
    int n_starts;
    int n_carves;
    int n_backs;
    int n_fins;
    int max_depth;

    biased_dfs_maze_carver_core #(
        .MAX_DIM     (GRID_DIM),
        .STACK_DEPTH (STACK_CAP)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // start_x[5:0], start_y[11:6], rand_axis[19:12], rand_pick[20], rand_invert[28:21]
        .s_axis_tdata  (s_axis_tdata),
        // action[0]
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // cell_x[5:0], cell_y[11:6], wall_x[17:12], wall_y[23:18], stack_depth[34:24]
        .m_axis_tdata  (m_axis_tdata),
        // event_res[1:0]
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void dir_offset(input int d, output int ox, output int oy);
        ox = 0;
        oy = 0;
        case (d)
            DIR_N: oy = -1;
            DIR_S: oy = 1;
            DIR_E: ox = 1;
            default: ox = -1;
        endcase
    endfunction

    function automatic logic [11:0] cell_index(input int x, input int y);
        return {6'(y), 6'(x)};
    endfunction

    function automatic carve_res_t carve_step(input carve_req_t rq);
        carve_res_t o;
        logic [5:0] cx;
        logic [5:0] cy;
        logic [8:0] bias;
        logic [11:0] top;
        bit room_open [4];
        bit vopen;
        bit hopen;
        bit vert;
        int ox;
        int oy;
        int ax;
        int ay;
        int sel;
        int first;
        int w;
        int h;
        int wx;
        int wy;
        o = '0;
        w = int'(cfg_w | 6'd1);
        h = int'(cfg_h | 6'd1);
        if (!rq.action)
        begin
            foreach (carved_bits[i]) carved_bits[i] = 1'b0;
            top = {rq.start_y & 6'h3E, rq.start_x & 6'h3E};
            carved_bits[top] = 1'b1;
            path_cells[0] = top;
            path_len = 1;
            bias_inv = 1'b0;
            o.ev = EV_STARTED;
        end
        else if (path_len == 0)
        begin
            o.ev = EV_FINISHED;
        end
        else
        begin
            top = path_cells[path_len - 1];
            cx = top[5:0];
            cy = top[11:6];
            for (int d = 0; d < 4; d++)
            begin
                dir_offset(d, ox, oy);
                ax = int'(cx) + ox;
                ay = int'(cy) + oy;
                room_open[d] = ax >= 2 && ax <= w - 1 && ay >= 2 && ay <= h - 1
                               && !carved_bits[cell_index(ax + ox, ay + oy)];
            end
            vopen = room_open[DIR_N] || room_open[DIR_S];
            hopen = room_open[DIR_E] || room_open[DIR_W];
            sel = -1;
            if ((vopen || hopen) && path_len < STACK_CAP)
            begin
                bias = bias_inv ? 9'd256 - {1'b0, cfg_bias} : {1'b0, cfg_bias};
                vert = (vopen && hopen) ? ({1'b0, rq.rand_axis} > bias) : vopen;
                first = vert ? int'(DIR_N) : int'(DIR_E);
                if (room_open[first] && room_open[first + 1])
                    sel = rq.rand_pick ? first : first + 1;
                else
                    sel = room_open[first] ? first : first + 1;
            end
            if (sel < 0)
            begin
                path_len--;
                o.ev = (path_len != 0) ? EV_BACKTRACK : EV_FINISHED;
            end
            else
            begin
                dir_offset(sel, ox, oy);
                wx = int'(cx) + ox;
                wy = int'(cy) + oy;
                carved_bits[cell_index(wx, wy)] = 1'b1;
                carved_bits[cell_index(wx + ox, wy + oy)] = 1'b1;
                path_cells[path_len] = cell_index(wx + ox, wy + oy);
                path_len++;
                o.ev = EV_CARVED;
                o.wall_x = 6'(wx);
                o.wall_y = 6'(wy);
            end
            if (rq.rand_invert < cfg_flip)
                bias_inv = ~bias_inv;
        end
        if (path_len != 0)
        begin
            top = path_cells[path_len - 1];
            o.cell_x = top[5:0];
            o.cell_y = top[11:6];
        end
        o.depth = 11'(path_len);
        return o;
    endfunction

    function automatic plan_row_t fixed_row(input logic act, input logic [5:0] sx,
            input logic [5:0] sy, input logic [7:0] ax, input logic pk,
            input logic [7:0] iv, input ev_t ev, input logic [5:0] cx,
            input logic [5:0] cy, input logic [10:0] dep);
        plan_row_t r;
        r.req = '{act, sx, sy, ax, pk, iv};
        r.typed = 1'b1;
        r.res = '{ev, cx, cy, 6'd0, 6'd0, dep};
        return r;
    endfunction

    function automatic plan_row_t step_row(input logic [7:0] ax, input logic pk,
            input logic [7:0] iv);
        plan_row_t r;
        r.req = '{1'b1, 6'h3F, 6'h3F, ax, pk, iv};
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    function automatic void add_row(input plan_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic carve_req_t rand_req(input logic act);
        carve_req_t rq;
        rq.action      = act;
        rq.start_x     = 6'($urandom);
        rq.start_y     = 6'($urandom);
        rq.rand_axis   = 8'($urandom);
        rq.rand_pick   = 1'($urandom);
        rq.rand_invert = 8'($urandom);
        return rq;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        n_errors++;
        if (n_errors <= MAX_REPORT)
            $display("mismatch on result %0d: %s got %0d, expected %0d",
                     n_results, what, got_v, want_v);
    endtask

    task automatic send_req(input carve_req_t rq, input logic typed, input carve_res_t fixed);
        carve_res_t pred;
        if (tx_idle_on)
        begin
            while ($urandom_range(0, 99) < 35)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.action;
        s_axis_tdata  <= {3'b000, rq.rand_invert, rq.rand_pick, rq.rand_axis,
                          rq.start_y, rq.start_x};
        do @(posedge clk); while (!s_axis_tready);
        pred = carve_step(rq);
        expected_results.insert(expected_results.size(), typed ? fixed : pred);
        n_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] w, input logic [7:0] h,
            input logic [7:0] b, input logic [7:0] f);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= CFG_BIAS_LEVEL;
        cfg_data  <= b;
        @(posedge clk);
        cfg_index <= CFG_INVERT_CHANCE;
        cfg_data  <= f;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_w    = w[5:0];
        cfg_h    = h[5:0];
        cfg_bias = b;
        cfg_flip = f;
        n_settings++;
    endtask

    // mostly a start and a walk of rooms to 2*rooms+2 steps, which may finish the grid; some single noise requests
    task automatic run_walks(input int n_items);
        carve_req_t rq;
        int sent;
        int rooms;
        int run_len;
        int w;
        int h;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_req(rand_req(1'($urandom)), 1'b0, '0);
                sent++;
            end
            else
            begin
                w = int'(cfg_w | 6'd1);
                h = int'(cfg_h | 6'd1);
                rq = rand_req(1'b0);
                if (w >= 3)
                    rq.start_x = 6'($urandom_range(2, w - 1));
                if (h >= 3)
                    rq.start_y = 6'($urandom_range(2, h - 1));
                send_req(rq, 1'b0, '0);
                sent++;
                rooms = ((w - 1) / 2) * ((h - 1) / 2);
                run_len = $urandom_range(rooms, 2 * rooms + 2);
                for (int k = 0; k < run_len && sent < n_items; k++)
                begin
                    send_req(rand_req(1'b1), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.ev     = ev_t'(m_axis_tuser);
            got.cell_x = m_axis_tdata[5:0];
            got.cell_y = m_axis_tdata[11:6];
            got.wall_x = m_axis_tdata[17:12];
            got.wall_y = m_axis_tdata[23:18];
            got.depth  = m_axis_tdata[34:24];
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no request pending", got.ev, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.ev != want.ev)
                    report_mismatch("event_res", got.ev, want.ev);
                if (got.cell_x != want.cell_x)
                    report_mismatch("cell_x", got.cell_x, want.cell_x);
                if (got.cell_y != want.cell_y)
                    report_mismatch("cell_y", got.cell_y, want.cell_y);
                if (got.wall_x != want.wall_x)
                    report_mismatch("wall_x", got.wall_x, want.wall_x);
                if (got.wall_y != want.wall_y)
                    report_mismatch("wall_y", got.wall_y, want.wall_y);
                if (got.depth != want.depth)
                    report_mismatch("stack_depth", got.depth, want.depth);
                if (m_axis_tdata[OUT_DATA_W-1:35] != '0)
                    report_mismatch("tdata padding", m_axis_tdata[OUT_DATA_W-1:35], 0);
            end
            case (got.ev)
                EV_STARTED: n_starts++;
                EV_CARVED: n_carves++;
                EV_BACKTRACK: n_backs++;
                default: n_fins++;
            endcase
            if (int'(got.depth) > max_depth)
                max_depth = int'(got.depth);
            n_results++;
        end
        // long hold-off lets the core fill up and stall its input
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !rx_idle_on || ($urandom_range(0, 99) >= 35);
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYC)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results pending",
                 cycle_count, expected_results.size());
        $display("biased_dfs_maze_carver_core_tb NOT OK");
        $finish;
    end

    initial
    begin
        int n_items;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_GRID_WIDTH;
        cfg_data      = '0;
        foreach (carved_bits[i]) carved_bits[i] = 1'b0;
        path_len   = 0;
        bias_inv   = 1'b0;
        cfg_w      = 6'd63;
        cfg_h      = 6'd63;
        cfg_bias   = 8'd128;
        cfg_flip   = 8'd5;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // step before any start, start off the interior, pop to empty, step on empty
        add_row(fixed_row(1'b1, 6'd0, 6'd0, 8'd0, 1'b0, 8'd255,
                          EV_FINISHED, 6'd0, 6'd0, 11'd0));
        add_row(fixed_row(1'b0, 6'd0, 6'd0, 8'd0, 1'b0, 8'd255,
                          EV_STARTED, 6'd0, 6'd0, 11'd1));
        add_row(fixed_row(1'b1, 6'd0, 6'd0, 8'd0, 1'b0, 8'd0,
                          EV_FINISHED, 6'd0, 6'd0, 11'd0));
        add_row(fixed_row(1'b1, 6'd0, 6'd0, 8'd0, 1'b0, 8'd0,
                          EV_FINISHED, 6'd0, 6'd0, 11'd0));
        // far corner, odd coordinates round down; axis at and around the bias
        add_row(fixed_row(1'b0, 6'd63, 6'd63, 8'd255, 1'b1, 8'd255,
                          EV_STARTED, 6'd62, 6'd62, 11'd1));
        add_row(step_row(8'd255, 1'b1, 8'd255));
        add_row(step_row(8'd0, 1'b0, 8'd255));
        add_row(step_row(8'd128, 1'b1, 8'd4));
        add_row(step_row(8'd128, 1'b0, 8'd5));
        // center and edge starts: every direction and both picks
        add_row(fixed_row(1'b0, 6'd33, 6'd33, 8'd0, 1'b0, 8'd255,
                          EV_STARTED, 6'd32, 6'd32, 11'd1));
        add_row(step_row(8'd255, 1'b1, 8'd255));
        add_row(fixed_row(1'b0, 6'd32, 6'd32, 8'd0, 1'b0, 8'd255,
                          EV_STARTED, 6'd32, 6'd32, 11'd1));
        add_row(step_row(8'd255, 1'b0, 8'd255));
        add_row(step_row(8'd0, 1'b1, 8'd255));
        add_row(step_row(8'd0, 1'b0, 8'd255));
        add_row(fixed_row(1'b0, 6'd2, 6'd2, 8'd0, 1'b0, 8'd255,
                          EV_STARTED, 6'd2, 6'd2, 11'd1));
        add_row(step_row(8'd129, 1'b1, 8'd0));
        add_row(step_row(8'd128, 1'b0, 8'd255));
        add_row(step_row(8'd255, 1'b1, 8'd255));
        add_row(fixed_row(1'b0, 6'd42, 6'd21, 8'd170, 1'b1, 8'd85,
                          EV_STARTED, 6'd42, 6'd20, 11'd1));
        add_row(step_row(8'd170, 1'b1, 8'd85));
        add_row(step_row(8'd85, 1'b0, 8'd170));
        add_row(fixed_row(1'b0, 6'd62, 6'd2, 8'd0, 1'b0, 8'd255,
                          EV_STARTED, 6'd62, 6'd2, 11'd1));
        add_row(step_row(8'd255, 1'b1, 8'd255));
        add_row(step_row(8'd0, 1'b0, 8'd255));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) send_req(plan[i].req, plan[i].typed, plan[i].res);
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    set_config(8'd63, 8'd63, 8'd0, 8'd0);
                    n_items = 260;
                end
                1:
                begin
                    set_config(8'hC5, 8'h45, 8'd255, 8'd255);
                    n_items = 110;
                end
                2:
                begin
                    // sizes below the minimum
                    set_config(8'd2, 8'd0, 8'd128, 8'd5);
                    n_items = 40;
                end
                3:
                begin
                    set_config(8'd17, 8'd12, 8'd200, 8'd40);
                    n_items = 200;
                    hold_req++;
                end
                4:
                begin
                    set_config(8'd31, 8'd9, 8'd64, 8'd128);
                    n_items = 200;
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                end
                default:
                begin
                    set_config({2'($urandom), 6'($urandom_range(5, 33))},
                               {2'($urandom), 6'($urandom_range(5, 33))},
                               8'($urandom), 8'($urandom_range(0, 64)));
                    n_items = 120;
                    if (p == 7)
                        hold_req++;
                end
            endcase
            run_walks(n_items);
            drain_results();
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
        end

        $display("%0d requests under %0d register settings: %0d starts, %0d carves,",
                 n_sent, n_settings + 1, n_starts, n_carves);
        $display("%0d backtracks, %0d finishes, deepest path %0d cells, %0d mismatches, %0d cycles",
                 n_backs, n_fins, max_depth, n_errors, cycle_count);
        if (n_errors == 0)
            $display("biased_dfs_maze_carver_core_tb OK");
        else
            $display("biased_dfs_maze_carver_core_tb NOT OK");
        $finish;
    end

endmodule
